// ===== hw/rtl/qcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// qcsm_pkg - shared types and constants of the quadrature counter speed meter
// Counter width, arithmetic widths, input action codes, register indexes and
// the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package qcsm_pkg;

  // Position counter width (wraps modulo 2^COUNT_WIDTH), legal range 16..64
  localparam int COUNT_WIDTH = 32;

  // Field widths
  localparam int PPR_W   = 16;
  localparam int MS_W    = 16;
  localparam int DEN_W   = PPR_W + MS_W;     // pulses_per_rev * elapsed_ms
  localparam int SPEED_W = 24;               // signed Q15.8
  localparam int QUOT_W  = SPEED_W - 1;      // magnitude bits below saturation

  // Magnitudes at or above 2^MAG_W always saturate
  localparam int EXT_W   = 64;
  localparam int MAG_W   = 40;

  // 256000 = 1000 ms/s * 256 (Q8) = 2^18 - 2^12 - 2^11
  localparam int SCALE_SH_A = 18;
  localparam int SCALE_SH_B = 12;
  localparam int SCALE_SH_C = 11;
  localparam int NUM_W      = MAG_W + SCALE_SH_A;
  localparam int HI_W       = NUM_W - QUOT_W;

  // Divider step counter
  localparam int STEP_W = $clog2(QUOT_W);

  // Saturation limits
  localparam logic signed [SPEED_W-1:0] SPEED_POS_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_NEG_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic [QUOT_W-1:0]         MAG_MAX       = {QUOT_W{1'b1}};

  // Input action codes
  localparam logic [1:0] ACT_EDGE_A  = 2'd0;
  localparam logic [1:0] ACT_EDGE_B  = 2'd1;
  localparam logic [1:0] ACT_MEASURE = 2'd2;

  // Register map (word index taken from paddr[2])
  localparam int         ADDR_W     = 3;
  localparam int         DATA_W     = 32;
  localparam logic       REG_PPR    = 1'b0;
  localparam logic       REG_INVERT = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [PPR_W-1:0] pulses_per_rev;
    logic             direction_invert;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic count_en;   // apply one edge step to the position counter
    logic capture;    // snapshot count change, window and divisor
    logic scale;      // form the scaled numerator
    logic check;      // early saturation check, divider setup
    logic div_step;   // one restoring-division step
    logic load_out;   // write the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_div;   // zero window or saturated: no division needed
  } dp_stat_t;

endpackage

// ===== hw/rtl/quadrature_counter_speed_meter.sv =====
// ----------------------------------------------------------------------------
// quadrature_counter_speed_meter - x4 quadrature decoder with speed measurement
// Counts encoder edges and reports windowed wheel speed in Q15.8 rev/s.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): action selects an edge on A, an edge on
//   B (levels sampled after the edge in level_a/level_b) or a measurement over
//   elapsed_ms. Edge transactions produce no result.
//   A measure transaction produces one result transaction on the output
//   channel (out_valid/out_ready) after acceptance: capture, scale,
//   range check, 23 restoring-division steps (one quotient bit each), then the
//   result register. A saturated or zero-window measurement still runs the
//   same sequence but skips the division steps.
//   The input is taken again once the result is in the output register, so
//   edges keep counting while a result waits. If the receiver stalls, a second
//   measurement finishes and holds in its last step until the register frees.
//   Configuration: APB, pulses_per_rev at 0x0, direction_invert at 0x4.
//   Reset clears the position count and snapshot, sets pulses_per_rev to 1,
//   direction_invert to 0, and empties the output register.
// ----------------------------------------------------------------------------
module quadrature_counter_speed_meter (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic                                level_a,
  input  logic                                level_b,
  input  logic [qcsm_pkg::MS_W-1:0]           elapsed_ms,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qcsm_pkg::SPEED_W-1:0] speed_signed,
  output logic [qcsm_pkg::QUOT_W-1:0]         speed_magnitude,
  output logic [qcsm_pkg::MS_W-1:0]           window_ms,
  output logic                                zero_window_fault,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qcsm_pkg::ADDR_W-1:0]         paddr,
  input  logic [qcsm_pkg::DATA_W-1:0]         pwdata,
  output logic [qcsm_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  qcsm_pkg::cfg_t     cfg;
  qcsm_pkg::dp_cmd_t  cmd;
  qcsm_pkg::dp_stat_t stat;

  // Configuration registers
  qcsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  qcsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Counter and arithmetic
  qcsm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .stat              (stat),
    .action            (action),
    .level_a           (level_a),
    .level_b           (level_b),
    .elapsed_ms        (elapsed_ms),
    .speed_signed      (speed_signed),
    .speed_magnitude   (speed_magnitude),
    .window_ms         (window_ms),
    .zero_window_fault (zero_window_fault)
  );

endmodule

// ===== hw/rtl/qcsm_regs.sv =====
// ----------------------------------------------------------------------------
// qcsm_regs - APB configuration registers
// Holds pulses_per_rev (reset 1) and direction_invert (reset 0).
// ----------------------------------------------------------------------------
module qcsm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qcsm_pkg::ADDR_W-1:0]  paddr,
  input  logic [qcsm_pkg::DATA_W-1:0]  pwdata,
  output logic [qcsm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output qcsm_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_rev   <= qcsm_pkg::PPR_W'(1);
      cfg.direction_invert <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        qcsm_pkg::REG_PPR:    cfg.pulses_per_rev   <= pwdata[qcsm_pkg::PPR_W-1:0];
        qcsm_pkg::REG_INVERT: cfg.direction_invert <= pwdata[0];
        default:              ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[2])
      qcsm_pkg::REG_PPR:    prdata = qcsm_pkg::DATA_W'(cfg.pulses_per_rev);
      qcsm_pkg::REG_INVERT: prdata = qcsm_pkg::DATA_W'(cfg.direction_invert);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/qcsm_datapath.sv =====
// ----------------------------------------------------------------------------
// qcsm_datapath - position counter, scaling, restoring divider, result register
// Speed = delta * 256000 / (ppr * ms), one quotient bit per div_step.
// ----------------------------------------------------------------------------
module qcsm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  qcsm_pkg::cfg_t                      cfg,
  input  qcsm_pkg::dp_cmd_t                   cmd,
  output qcsm_pkg::dp_stat_t                  stat,
  input  logic [1:0]                          action,
  input  logic                                level_a,
  input  logic                                level_b,
  input  logic [qcsm_pkg::MS_W-1:0]           elapsed_ms,
  output logic signed [qcsm_pkg::SPEED_W-1:0] speed_signed,
  output logic [qcsm_pkg::QUOT_W-1:0]         speed_magnitude,
  output logic [qcsm_pkg::MS_W-1:0]           window_ms,
  output logic                                zero_window_fault
);

  localparam int CW = qcsm_pkg::COUNT_WIDTH;

  // Counter state
  logic [CW-1:0] position;
  logic [CW-1:0] last_count;

  // Measurement working registers
  logic                          neg_r;
  logic [CW-1:0]                 mag_r;
  logic [qcsm_pkg::MS_W-1:0]     ms_r;
  logic                          zero_r;
  logic [qcsm_pkg::DEN_W-1:0]    den_r;
  logic                          big_r;
  logic [qcsm_pkg::NUM_W-1:0]    num_r;
  logic                          sat_r;
  logic [qcsm_pkg::DEN_W-1:0]    rem_r;
  logic [qcsm_pkg::QUOT_W-1:0]   q_r;

  logic                          step_up;
  logic [CW-1:0]                 diff;
  logic [qcsm_pkg::PPR_W-1:0]    ppr_eff;
  logic [qcsm_pkg::EXT_W-1:0]    mag_ext;
  logic [qcsm_pkg::MAG_W-1:0]    mag_cap;
  logic [qcsm_pkg::HI_W-1:0]     num_hi;
  logic [qcsm_pkg::DEN_W:0]      trial;
  logic [qcsm_pkg::DEN_W:0]      den_ext;

  // Edge direction: A counts up on A==B, B counts up on A!=B
  always_comb begin
    step_up = (action == qcsm_pkg::ACT_EDGE_A) ? (level_a == level_b)
                                                : (level_a != level_b);
    step_up = step_up ^ cfg.direction_invert;
  end

  assign diff    = position - last_count;
  assign ppr_eff = (cfg.pulses_per_rev == '0) ? qcsm_pkg::PPR_W'(1) : cfg.pulses_per_rev;
  assign mag_ext = qcsm_pkg::EXT_W'(mag_r);
  assign mag_cap = mag_ext[qcsm_pkg::MAG_W-1:0];
  assign num_hi  = num_r[qcsm_pkg::NUM_W-1:qcsm_pkg::QUOT_W];
  assign den_ext = {1'b0, den_r};
  assign trial   = {rem_r, num_r[qcsm_pkg::QUOT_W-1]};

  assign stat.skip_div = sat_r | zero_r;

  // Position counter and snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      last_count <= '0;
    end else if (cmd.count_en) begin
      position <= step_up ? position + CW'(1) : position - CW'(1);
    end else if (cmd.capture) begin
      last_count <= position;
    end
  end

  // Measurement pipeline: capture, scale, check, divide
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg_r  <= diff[CW-1];
      mag_r  <= diff[CW-1] ? (~diff + CW'(1)) : diff;
      ms_r   <= elapsed_ms;
      zero_r <= (elapsed_ms == '0);
      den_r  <= qcsm_pkg::DEN_W'(ppr_eff) * qcsm_pkg::DEN_W'(elapsed_ms);
    end
    if (cmd.scale) begin
      big_r <= (mag_ext[qcsm_pkg::EXT_W-1:qcsm_pkg::MAG_W] != '0);
      num_r <= (qcsm_pkg::NUM_W'(mag_cap) << qcsm_pkg::SCALE_SH_A)
             - (qcsm_pkg::NUM_W'(mag_cap) << qcsm_pkg::SCALE_SH_B)
             - (qcsm_pkg::NUM_W'(mag_cap) << qcsm_pkg::SCALE_SH_C);
    end
    // Quotient reaches 2^23 exactly when the high part is not below the divisor
    if (cmd.check) begin
      sat_r <= big_r | (num_hi >= qcsm_pkg::HI_W'(den_r));
      rem_r <= num_hi[qcsm_pkg::DEN_W-1:0];
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (trial >= den_ext) begin
        rem_r <= qcsm_pkg::DEN_W'(trial - den_ext);
        q_r   <= {q_r[qcsm_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[qcsm_pkg::DEN_W-1:0];
        q_r   <= {q_r[qcsm_pkg::QUOT_W-2:0], 1'b0};
      end
      num_r <= num_r << 1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      window_ms         <= ms_r;
      zero_window_fault <= zero_r;
      if (zero_r) begin
        speed_signed    <= '0;
        speed_magnitude <= '0;
      end else if (sat_r) begin
        speed_signed    <= neg_r ? qcsm_pkg::SPEED_NEG_MIN : qcsm_pkg::SPEED_POS_MAX;
        speed_magnitude <= qcsm_pkg::MAG_MAX;
      end else begin
        speed_signed    <= neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
        speed_magnitude <= q_r;
      end
    end
  end

endmodule

// ===== hw/rtl/qcsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qcsm_ctrl - sequencing state machine
// Takes input transactions, steps the datapath through a measurement and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module qcsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  output logic                out_valid,
  input  logic                out_ready,
  output qcsm_pkg::dp_cmd_t   cmd,
  input  qcsm_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_CHECK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [qcsm_pkg::STEP_W-1:0] step_cnt;
  logic                        accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  // Datapath commands
  always_comb begin
    cmd.count_en = accept & ((action == qcsm_pkg::ACT_EDGE_A) ||
                             (action == qcsm_pkg::ACT_EDGE_B));
    cmd.capture  = accept & (action == qcsm_pkg::ACT_MEASURE);
    cmd.scale    = (state == S_SCALE);
    cmd.check    = (state == S_CHECK);
    cmd.div_step = (state == S_DIV) & ~stat.skip_div;
    cmd.load_out = (state == S_FINISH) & (~out_valid | out_ready);
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (stat.skip_div ||
              step_cnt == qcsm_pkg::STEP_W'(qcsm_pkg::QUOT_W - 1)) begin
            state <= S_FINISH;
          end
          step_cnt <= step_cnt + qcsm_pkg::STEP_W'(1);
        end
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while holding an untaken result");

  // Divider never runs past the quotient width
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (step_cnt < qcsm_pkg::STEP_W'(qcsm_pkg::QUOT_W)))
    else $error("divider step counter out of range");

  // A new result only appears from the finish state
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("out_valid raised outside the finish state");

  // A measure transaction starts the measurement sequence
  a_measure_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == qcsm_pkg::ACT_MEASURE) |=> (state == S_SCALE))
    else $error("measure transaction did not start the sequence");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the quadrature counter speed meter
// Sends edge, measure and unused-action transactions with random idle gaps
// on both sides. It keeps its own copy of the position counter, the snapshot
// and the registers, predicts each speed result and compares every result
// field by field. Registers are written over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [qcsm_pkg::ADDR_W-1:0] ADDR_PPR    = {qcsm_pkg::REG_PPR, 2'b00};
  localparam logic [qcsm_pkg::ADDR_W-1:0] ADDR_INVERT = {qcsm_pkg::REG_INVERT, 2'b00};
  // 1000 ms per second, times 256 for the Q8 fraction
  localparam logic [63:0] RPS_SCALE    = 64'd256000;
  localparam logic [63:0] SAT_POS      = (64'd1 << (qcsm_pkg::SPEED_W - 1)) - 64'd1;
  localparam logic [63:0] SAT_NEG      = 64'd1 << (qcsm_pkg::SPEED_W - 1);
  localparam logic [63:0] SAT_SHORTCUT = 64'd1 << qcsm_pkg::MAG_W;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [qcsm_pkg::SPEED_W-1:0] spd;
    logic [qcsm_pkg::QUOT_W-1:0]         mag;
    logic [qcsm_pkg::MS_W-1:0]           win;
    logic                                fault;
  } speed_rpt_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [1:0]                          action;
  logic                                level_a;
  logic                                level_b;
  logic [qcsm_pkg::MS_W-1:0]           elapsed_ms;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [qcsm_pkg::SPEED_W-1:0] speed_signed;
  logic [qcsm_pkg::QUOT_W-1:0]         speed_magnitude;
  logic [qcsm_pkg::MS_W-1:0]           window_ms;
  logic                                zero_window_fault;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [qcsm_pkg::ADDR_W-1:0]         paddr;
  logic [qcsm_pkg::DATA_W-1:0]         pwdata;
  logic [qcsm_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  // Predicted speed results, oldest first
  speed_rpt_t speed_reports_q[$];

  // Mirror of the counter state and registers
  logic [qcsm_pkg::COUNT_WIDTH-1:0] pos_q;
  logic [qcsm_pkg::COUNT_WIDTH-1:0] snap_q;
  logic [qcsm_pkg::PPR_W-1:0]       ppr_q;
  logic                             inv_q;

  // Encoder levels for well-formed quadrature sequences
  logic enc_a;
  logic enc_b;

  bit idle_on;
  int err_cnt;
  int n_edge;
  int n_measure;
  int n_fault;
  int n_sat;
  int n_checked;

  quadrature_counter_speed_meter i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .level_a           (level_a),
    .level_b           (level_b),
    .elapsed_ms        (elapsed_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .speed_signed      (speed_signed),
    .speed_magnitude   (speed_magnitude),
    .window_ms         (window_ms),
    .zero_window_fault (zero_window_fault),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t ERROR %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      flag_error($sformatf("%s: expected %0d, got %0d", name, want, got));
    end
  endtask

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (!idle_on || $urandom_range(0, 99) < 60) begin
      return 0;
    end
    return idle_len();
  endfunction

  function automatic logic [qcsm_pkg::MS_W-1:0] measure_window();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return qcsm_pkg::MS_W'($urandom);
      default: return qcsm_pkg::MS_W'($urandom_range(1, 100));
    endcase
  endfunction

  // Count update and speed prediction for one accepted transaction
  task automatic predict_item(input logic [1:0] act, input logic la, input logic lb,
                              input logic [qcsm_pkg::MS_W-1:0] ms);
    logic                             up;
    logic [qcsm_pkg::COUNT_WIDTH-1:0] delta;
    logic [qcsm_pkg::COUNT_WIDTH-1:0] delta_neg;
    logic [qcsm_pkg::PPR_W-1:0]       ppr_eff;
    logic [63:0]                      mag;
    logic [63:0]                      den;
    logic [63:0]                      quo;
    logic [63:0]                      clip;
    speed_rpt_t                       rpt;
    case (act)
      qcsm_pkg::ACT_EDGE_A, qcsm_pkg::ACT_EDGE_B: begin
        up = (act == qcsm_pkg::ACT_EDGE_A) ? (la == lb) : (la != lb);
        if (inv_q) up = !up;
        pos_q = up ? pos_q + qcsm_pkg::COUNT_WIDTH'(1) : pos_q - qcsm_pkg::COUNT_WIDTH'(1);
        n_edge++;
      end
      qcsm_pkg::ACT_MEASURE: begin
        delta     = pos_q - snap_q;
        delta_neg = ~delta + qcsm_pkg::COUNT_WIDTH'(1);
        mag       = delta[qcsm_pkg::COUNT_WIDTH-1] ? 64'(delta_neg) : 64'(delta);
        snap_q    = pos_q;
        rpt       = '0;
        rpt.win   = ms;
        n_measure++;
        if (ms == '0) begin
          // zero window: fault, speed forced to zero
          rpt.fault = 1'b1;
          n_fault++;
        end else begin
          ppr_eff = (ppr_q == '0) ? qcsm_pkg::PPR_W'(1) : ppr_q;
          den     = 64'(ppr_eff) * 64'(ms);
          quo     = (mag >= SAT_SHORTCUT) ? SAT_NEG : (mag * RPS_SCALE) / den;
          if (delta[qcsm_pkg::COUNT_WIDTH-1]) begin
            clip = (quo > SAT_NEG) ? SAT_NEG : quo;
            clip = 64'd0 - clip;
          end else begin
            clip = (quo > SAT_POS) ? SAT_POS : quo;
          end
          rpt.spd = clip[qcsm_pkg::SPEED_W-1:0];
          rpt.mag = (quo > SAT_POS) ? SAT_POS[qcsm_pkg::QUOT_W-1:0]
                                    : quo[qcsm_pkg::QUOT_W-1:0];
          if (quo > SAT_POS) n_sat++;
        end
        speed_reports_q.push_back(rpt);
      end
      default: ;
    endcase
  endtask

  // One input transaction, preceded by a random gap
  task automatic send_item(input logic [1:0] act, input logic la, input logic lb,
                           input logic [qcsm_pkg::MS_W-1:0] ms);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= act;
    level_a    <= la;
    level_b    <= lb;
    elapsed_ms <= ms;
    do @(posedge clk); while (!in_ready);
    predict_item(act, la, lb, ms);
  endtask

  // Next Gray-code step of the encoder in one direction
  task automatic quad_step(input logic dir);
    if (enc_a ^ enc_b ^ dir) begin
      enc_b = ~enc_b;
      send_item(qcsm_pkg::ACT_EDGE_B, enc_a, enc_b, qcsm_pkg::MS_W'($urandom));
    end else begin
      enc_a = ~enc_a;
      send_item(qcsm_pkg::ACT_EDGE_A, enc_a, enc_b, qcsm_pkg::MS_W'($urandom));
    end
  endtask

  // Stop sending and wait for every pending result
  task automatic drain_results(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (speed_reports_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [qcsm_pkg::ADDR_W-1:0] addr,
                          input logic [qcsm_pkg::DATA_W-1:0] wdata,
                          output logic [qcsm_pkg::DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers while idle, then read them back
  task automatic set_config(input logic [qcsm_pkg::PPR_W-1:0] ppr, input logic inv);
    logic [qcsm_pkg::DATA_W-1:0] rd;
    drain_results(SETTLE_CYCLES);
    apb_xfer(1'b1, ADDR_PPR, qcsm_pkg::DATA_W'(ppr), rd);
    apb_xfer(1'b1, ADDR_INVERT, qcsm_pkg::DATA_W'(inv), rd);
    ppr_q = ppr;
    inv_q = inv;
    apb_xfer(1'b0, ADDR_PPR, '0, rd);
    check_field("pulses_per_rev readback", longint'(ppr), longint'(rd));
    apb_xfer(1'b0, ADDR_INVERT, '0, rd);
    check_field("direction_invert readback", longint'(inv), longint'(rd));
  endtask

  // Reset register values: every count rule, zero window, ignored action
  task automatic test_directed();
    idle_on = 1'b1;
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, '0);
    send_item(qcsm_pkg::ACT_EDGE_A, 1'b1, 1'b1, '1);
    send_item(qcsm_pkg::ACT_EDGE_A, 1'b0, 1'b0, '0);
    send_item(qcsm_pkg::ACT_EDGE_A, 1'b1, 1'b0, '1);
    send_item(qcsm_pkg::ACT_EDGE_B, 1'b1, 1'b0, '0);
    send_item(qcsm_pkg::ACT_EDGE_B, 1'b0, 1'b1, '1);
    send_item(qcsm_pkg::ACT_EDGE_B, 1'b1, 1'b1, '0);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b1, 1'b1, qcsm_pkg::MS_W'(1));
    send_item(ACT_UNUSED, 1'b1, 1'b1, '1);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b1, '1);
    repeat (3) send_item(qcsm_pkg::ACT_EDGE_A, 1'b0, 1'b1, qcsm_pkg::MS_W'($urandom));
    send_item(qcsm_pkg::ACT_MEASURE, 1'b1, 1'b0, '1);
    send_item(qcsm_pkg::ACT_EDGE_B, 1'b0, 1'b1, '0);
    send_item(qcsm_pkg::ACT_EDGE_B, 1'b0, 1'b1, '0);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, '0);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, qcsm_pkg::MS_W'(1));
  endtask

  // Large count changes, both signs over a 1 ms window, then inverted over 2 ms
  task automatic test_saturation();
    set_config(qcsm_pkg::PPR_W'(1), 1'b0);
    repeat (40) quad_step(1'b0);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, qcsm_pkg::MS_W'(1));
    repeat (40) quad_step(1'b1);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, qcsm_pkg::MS_W'(1));
    set_config(qcsm_pkg::PPR_W'(1), 1'b1);
    repeat (40) quad_step(1'b0);
    send_item(qcsm_pkg::ACT_MEASURE, 1'b0, 1'b0, qcsm_pkg::MS_W'(2));
  endtask

  // Mostly well-formed encoder motion with random measurements, plus noise
  task automatic test_random_traffic(input int n_items,
                                     input logic [qcsm_pkg::PPR_W-1:0] ppr,
                                     input logic inv, input bit gaps);
    int   sent;
    int   pick;
    logic dir;
    bit   paused;
    set_config(ppr, inv);
    idle_on = gaps;
    sent    = 0;
    dir     = 1'($urandom);
    paused  = 1'b0;
    while (sent < n_items) begin
      // hold off once until every result is back
      if (!paused && sent >= n_items / 2) begin
        drain_results(0);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 9) == 0) dir = ~dir;
        quad_step(dir);
        sent++;
      end else if (pick < 87) begin
        send_item(qcsm_pkg::ACT_MEASURE, 1'($urandom), 1'($urandom), measure_window());
        sent++;
      end else if (pick < 97) begin
        send_item(2'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                  qcsm_pkg::MS_W'($urandom));
        sent++;
      end else begin
        send_item(ACT_UNUSED, 1'($urandom), 1'($urandom), qcsm_pkg::MS_W'($urandom));
      end
    end
  endtask

  // Receiver: ready runs with random stalls
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(negedge clk);
      if (idle_on) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (idle_len() - 1) @(negedge clk);
      end
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_check
    speed_rpt_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (speed_reports_q.size() == 0) begin
        flag_error("speed result with no measurement pending");
      end else begin
        want = speed_reports_q.pop_front();
        check_field("speed_signed", longint'($signed(want.spd)), longint'(speed_signed));
        check_field("speed_magnitude", longint'(want.mag), longint'(speed_magnitude));
        check_field("window_ms", longint'(want.win), longint'(window_ms));
        check_field("zero_window_fault", longint'(want.fault), longint'(zero_window_fault));
      end
    end
  end

  // Main sequence
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = qcsm_pkg::ACT_EDGE_A;
    level_a    = 1'b0;
    level_b    = 1'b0;
    elapsed_ms = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    pos_q      = '0;
    snap_q     = '0;
    ppr_q      = qcsm_pkg::PPR_W'(1);
    inv_q      = 1'b0;
    enc_a      = 1'b0;
    enc_b      = 1'b0;
    idle_on    = 1'b1;
    err_cnt    = 0;
    n_edge     = 0;
    n_measure  = 0;
    n_fault    = 0;
    n_sat      = 0;
    n_checked  = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_random_traffic(160, '1, 1'b1, 1'b1);
    test_random_traffic(160, '0, 1'b0, 1'b1);
    test_random_traffic(160, qcsm_pkg::PPR_W'($urandom_range(1, 8)), 1'b1, 1'b0);
    test_random_traffic(160, qcsm_pkg::PPR_W'($urandom_range(1, 65535)), 1'($urandom),
                        1'b1);
    test_random_traffic(160, qcsm_pkg::PPR_W'(1), 1'b0, 1'b1);
    drain_results(SETTLE_CYCLES);

    $display("Covered %0d edge and %0d measure transactions, %0d results checked",
             n_edge, n_measure, n_checked);
    $display("(%0d zero-window, %0d saturated), %0d errors", n_fault, n_sat, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
